### design/text_console_writer_macros.svh
// Assertion macros shared by the console writer.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tcw_pkg.sv
package tcw_pkg;

	// Field widths of the channels.
	localparam int ACT_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;

	// Default screen geometry.
	localparam int DEF_COLUMNS  = 80;
	localparam int DEF_ROWS     = 25;
	localparam int DEF_TAB_STOP = 8;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// Character codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CODE_LAST  = 8'h7F;

	// White-on-black space.
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [CHAR_W-1:0]  char_code;
		logic [COLOR_W-1:0] bg_colour;
		logic [COLOR_W-1:0] fg_colour;
		logic [IDX_W-1:0]   cell_index;
	} tcw_in_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_value;
		logic              scrolled;
	} tcw_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic sweep_start;
		logic sweep_step;
		logic finish;
	} tcw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_sweep;
		logic sweep_last;
		logic wr_pending;
		logic on_last_row;
	} tcw_stat_t;

endpackage

### design/tcw_stream_if.sv
interface tcw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/tcw_datapath.sv
module tcw_datapath import tcw_pkg::*; #(
	parameter int COLUMNS  = DEF_COLUMNS,
	parameter int ROWS     = DEF_ROWS,
	parameter int TAB_STOP = DEF_TAB_STOP
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tcw_in_t   item,
	input  tcw_cmd_t  cmd,
	output tcw_stat_t stat,
	output tcw_out_t  result
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CCW        = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);
	localparam int PW         = $clog2(TAB_STOP);
	localparam int NW         = $clog2(COLUMNS + TAB_STOP);

	// Captured item.
	tcw_in_t item_q;

	// Cursor state; the phase tracks the column modulo the tab stop.
	logic [CCW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic [PW-1:0]  phase_q;

	logic [ADDR_W-1:0] cur_lin;
	logic              is_put;
	logic              printable;
	logic              idx_ok;

	logic [NW-1:0]  col_calc;
	logic [PW-1:0]  phase_calc;
	logic           row_inc;
	logic           scroll;
	logic [CCW-1:0] col_nx;
	logic [RW-1:0]  row_nx;
	logic [PW-1:0]  phase_nx;
	logic           scroll_q;

	// Sweep pointer and the one-stage write pipeline behind the read.
	logic [ADDR_W-1:0] ptr_q;
	logic              copy_q;
	logic              copy_region;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              wr_copy_s1;
	logic              wr_vld_s1;

	// Cell store.
	logic [CELL_W-1:0] mem_q [CELL_COUNT];
	logic [CELL_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [CELL_W-1:0] wd;

	// Decoding of the held item.
	always_comb begin
		cur_lin   = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
		is_put    = (item_q.action == ACT_PUT);
		printable = (item_q.char_code inside {[CODE_SPACE:CODE_LAST]});
		idx_ok    = (32'(item_q.cell_index) < CELL_COUNT);
	end

	// Next cursor for a put.
	always_comb begin
		col_calc   = NW'(col_q);
		phase_calc = phase_q;
		row_inc    = 1'b0;
		case (item_q.char_code)
			CODE_BS: begin
				if (col_q != '0) begin
					col_calc   = NW'(col_q) - NW'(1);
					phase_calc = (phase_q == '0) ? PW'(TAB_STOP - 1) : phase_q - PW'(1);
				end
			end
			CODE_TAB: begin
				col_calc   = NW'(col_q) + NW'(TAB_STOP) - NW'(phase_q);
				phase_calc = '0;
			end
			CODE_CR: begin
				col_calc   = '0;
				phase_calc = '0;
			end
			CODE_LF: begin
				col_calc   = '0;
				phase_calc = '0;
				row_inc    = 1'b1;
			end
			default: begin
				if (printable) begin
					col_calc   = NW'(col_q) + NW'(1);
					phase_calc = (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
				end
			end
		endcase
		// Running off the last column wraps to the next row.
		if (col_calc >= NW'(COLUMNS)) begin
			col_calc   = '0;
			phase_calc = '0;
			row_inc    = 1'b1;
		end
		scroll   = row_inc && stat.on_last_row;
		row_nx   = (row_inc && !scroll) ? row_q + RW'(1) : row_q;
		col_nx   = CCW'(col_calc);
		phase_nx = phase_calc;
	end

	// Status towards the controller.
	always_comb begin
		stat.on_last_row = (row_q == RW'(ROWS - 1));
		stat.need_sweep  = (item_q.action == ACT_CLEAR) || (is_put && scroll);
		stat.sweep_last  = (ptr_q == ADDR_W'(CELL_COUNT - 1));
		stat.wr_pending  = wr_vld_s1;
	end

	// Cursor registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else if (cmd.exec) begin
			if (is_put) begin
				col_q   <= col_nx;
				row_q   <= row_nx;
				phase_q <= phase_nx;
			end else if (item_q.action == ACT_CLEAR) begin
				col_q   <= '0;
				row_q   <= '0;
				phase_q <= '0;
			end
		end
	end

	// Sweep pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_s1 <= 1'b0;
		end else begin
			wr_vld_s1 <= cmd.sweep_step;
		end
	end

	// Item capture, sweep pointer and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			scroll_q <= is_put && scroll;
		end
		if (cmd.sweep_start) begin
			ptr_q  <= '0;
			copy_q <= is_put;
		end else if (cmd.sweep_step) begin
			ptr_q <= ptr_q + ADDR_W'(1);
		end
		wr_addr_s1 <= ptr_q;
		wr_copy_s1 <= copy_region;
		if (cmd.finish) begin
			result.cursor_position <= POS_W'(cur_lin);
			result.cell_value      <= (item_q.action == ACT_READ && idx_ok) ? rd_q : '0;
			result.scrolled        <= scroll_q;
		end
	end

	// Memory port selection: sweep writes take the port over a printable store.
	always_comb begin
		copy_region = copy_q && (32'(ptr_q) < CELL_COUNT - COLUMNS);
		if (cmd.sweep_step) begin
			rd_addr = copy_region ? ADDR_W'(32'(ptr_q) + COLUMNS) : ptr_q;
		end else begin
			rd_addr = idx_ok ? ADDR_W'(item_q.cell_index) : '0;
		end
		we = wr_vld_s1 || (cmd.exec && is_put && printable);
		wa = wr_vld_s1 ? wr_addr_s1 : cur_lin;
		if (wr_vld_s1) begin
			wd = wr_copy_s1 ? rd_q : BLANK_CELL;
		end else begin
			wd = {item_q.bg_colour, item_q.fg_colour, item_q.char_code};
		end
	end

	// Cell store with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[rd_addr];
	end

endmodule

### design/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  tcw_stat_t stat,
	output tcw_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && in_ready_q;
			end
			ST_EXEC: begin
				cmd.exec        = 1'b1;
				cmd.sweep_start = stat.need_sweep;
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and registered handshake outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// A new result is loaded, or a waiting one stays until its transfer.
			out_valid_q <= cmd.finish || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q <= stat.need_sweep ? ST_SWEEP : ST_FINISH;
				end
				ST_SWEEP: begin
					if (stat.sweep_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

### design/text_console_writer.sv
// Channel    Direction  Payload
// request    in         action, char_code, bg_colour, fg_colour, cell_index
// response   out        cursor_position, cell_value, scrolled
//
// A put, a read or an ignored action goes from transfer through the execute and finish states to its result.
// A scroll or a clear sweeps the cell store once through its single write port,
// one cell a cycle, then passes through a flush state before the result.
// One item is in work at a time; the next request transfer may come while a
// result still waits in the output register, and a result is held until taken.
// Reset homes the cursor; the cell store holds nothing defined until cleared.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS  = DEF_COLUMNS,
	parameter int ROWS     = DEF_ROWS,
	parameter int TAB_STOP = DEF_TAB_STOP
) (
	input logic         clk,
	input logic         arst_n,
	tcw_stream_if.sink   request,
	tcw_stream_if.source response
);

	`include "text_console_writer_macros.svh"

	tcw_cmd_t  cmd;
	tcw_stat_t stat;

	// Sequencing of each item.
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (response.valid),
		.out_ready (response.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Cursor, cell store and result registers.
	tcw_datapath #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (request.payload),
		.cmd    (cmd),
		.stat   (stat),
		.result (response.payload)
	);

	// No request is taken while the store is being swept.
	`TCW_ASSERT_NOW(a_idle_no_sweep, request.ready, !cmd.sweep_step && !stat.wr_pending, "request ready during a sweep")
	// Only one item is in work at a time.
	`TCW_ASSERT_NEXT(a_one_item, request.valid && request.ready, !request.ready, "second item taken while busy")
	// A scroll always leaves the cursor on the bottom row.
	`TCW_ASSERT_NEXT(a_scroll_last_row, cmd.finish, !response.payload.scrolled || stat.on_last_row, "scroll left cursor off bottom row")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import tcw_pkg::*;

	// The action code that the block leaves unused.
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	localparam int CELL_COUNT    = DEF_COLUMNS * DEF_ROWS;
	localparam int INDEX_TOP     = (1 << IDX_W) - 1;
	localparam int RANDOM_ITEMS  = 1328;
	localparam int SETTLE_CYCLES = 32;
	// Worst case is every item a full sweep of the store plus both idle draws.
	localparam longint CYCLE_LIMIT = 12_000_000;

	typedef struct packed {
		tcw_in_t  item;
		logic     pinned;
		tcw_out_t result;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 22;

	// Directed rows. Pinned results are the ones that are plain from the behaviour;
	// the rest are left to the console predictor.
	localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
		// Fresh console: the spare action and ignored codes leave the cursor at home.
		'{'{ACT_SPARE, 8'hFF, 4'hF, 4'hF, 11'h7FF}, 1'b1, '{11'd0, 16'h0000, 1'b0}},
		'{'{ACT_PUT, 8'hFF, 4'h0, 4'h0, 11'h000}, 1'b1, '{11'd0, 16'h0000, 1'b0}},
		'{'{ACT_PUT, CODE_BS, 4'hF, 4'h0, 11'h555}, 1'b1, '{11'd0, 16'h0000, 1'b0}},
		// Clear, then read both ends of the store and past its end.
		'{'{ACT_CLEAR, 8'h00, 4'h0, 4'h0, 11'h000}, 1'b1, '{11'd0, 16'h0000, 1'b0}},
		'{'{ACT_READ, 8'h00, 4'h0, 4'h0, 11'd0}, 1'b1, '{11'd0, BLANK_CELL, 1'b0}},
		'{'{ACT_READ, 8'hFF, 4'hF, 4'hF, 11'd1999}, 1'b1, '{11'd0, BLANK_CELL, 1'b0}},
		'{'{ACT_READ, 8'h00, 4'h0, 4'h0, 11'd2000}, 1'b1, '{11'd0, 16'h0000, 1'b0}},
		'{'{ACT_READ, 8'h00, 4'h0, 4'h0, 11'h7FF}, 1'b1, '{11'd0, 16'h0000, 1'b0}},
		// Printable extremes with colour extremes.
		'{'{ACT_PUT, CODE_SPACE, 4'h0, 4'h0, 11'h7FF}, 1'b0, '0},
		'{'{ACT_PUT, CODE_LAST, 4'hF, 4'hF, 11'h000}, 1'b0, '0},
		'{'{ACT_READ, 8'h00, 4'h0, 4'h0, 11'd0}, 1'b0, '0},
		'{'{ACT_READ, 8'h00, 4'h0, 4'h0, 11'd1}, 1'b0, '0},
		// Control code without a meaning, and a high code.
		'{'{ACT_PUT, 8'h1F, 4'h3, 4'hC, 11'h000}, 1'b0, '0},
		'{'{ACT_PUT, 8'h80, 4'hC, 4'h3, 11'h000}, 1'b0, '0},
		// Cursor movement codes.
		'{'{ACT_PUT, CODE_TAB, 4'h0, 4'h0, 11'h000}, 1'b0, '0},
		'{'{ACT_PUT, CODE_BS, 4'h0, 4'h0, 11'h000}, 1'b0, '0},
		'{'{ACT_PUT, CODE_CR, 4'h0, 4'h0, 11'h000}, 1'b0, '0},
		'{'{ACT_PUT, CODE_LF, 4'h0, 4'h0, 11'h000}, 1'b0, '0},
		'{'{ACT_PUT, 8'h41, 4'hA, 4'h5, 11'h2AA}, 1'b0, '0},
		'{'{ACT_READ, 8'h00, 4'h0, 4'h0, 11'd80}, 1'b0, '0},
		'{'{ACT_SPARE, 8'h00, 4'h0, 4'h0, 11'h000}, 1'b0, '0},
		'{'{ACT_CLEAR, 8'hA5, 4'h5, 4'hA, 11'h2AA}, 1'b1, '{11'd0, 16'h0000, 1'b0}}
	};

	logic clk;
	logic arst_n;

	tcw_stream_if #(.payload_t(tcw_in_t))  request ();
	tcw_stream_if #(.payload_t(tcw_out_t)) response ();

	text_console_writer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request.sink),
		.response (response.source)
	);

	// Console state as the predictor sees it.
	logic [CELL_W-1:0] console_cells [CELL_COUNT];
	int                cursor_col;
	int                cursor_row;

	tcw_out_t    awaited_results [$];
	int          mismatch_count;
	longint      cycle_count;
	int unsigned sender_calm;
	int unsigned receiver_calm;

	// Result that the current directed row pins, read when its transfer happens.
	logic     pinned_valid;
	tcw_out_t pinned_result;

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Guard against a hung block.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_count = mismatch_count + 1;
	endtask

	// Idle draw for one transfer: mostly a uniform random wait, with stretches of none.
	function automatic int unsigned pick_wait(inout int unsigned calm_left);
		if (calm_left != 0) begin
			calm_left = calm_left - 1;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// Move the console up one row and blank the bottom row.
	function automatic void scroll_console();
		for (int i = 0; i < CELL_COUNT - DEF_COLUMNS; i++) begin
			console_cells[i] = console_cells[i + DEF_COLUMNS];
		end
		for (int i = CELL_COUNT - DEF_COLUMNS; i < CELL_COUNT; i++) begin
			console_cells[i] = BLANK_CELL;
		end
	endfunction

	// Apply one action to the predicted console and return the result it yields.
	function automatic tcw_out_t apply_action(input tcw_in_t req);
		tcw_out_t res;
		logic     did_scroll;

		res = '0;
		did_scroll = 1'b0;
		case (req.action)
			ACT_PUT: begin
				if (req.char_code == CODE_BS) begin
					if (cursor_col > 0) begin
						cursor_col = cursor_col - 1;
					end
				end else if (req.char_code == CODE_TAB) begin
					cursor_col = (cursor_col / DEF_TAB_STOP + 1) * DEF_TAB_STOP;
				end else if (req.char_code == CODE_CR) begin
					cursor_col = 0;
				end else if (req.char_code == CODE_LF) begin
					cursor_col = 0;
					cursor_row = cursor_row + 1;
				end else if (req.char_code >= CODE_SPACE && req.char_code <= CODE_LAST) begin
					console_cells[cursor_row * DEF_COLUMNS + cursor_col] =
						{req.bg_colour, req.fg_colour, req.char_code};
					cursor_col = cursor_col + 1;
				end
				// Wrap past the last column, then scroll past the last row.
				if (cursor_col >= DEF_COLUMNS) begin
					cursor_col = 0;
					cursor_row = cursor_row + 1;
				end
				if (cursor_row >= DEF_ROWS) begin
					scroll_console();
					cursor_row = DEF_ROWS - 1;
					did_scroll = 1'b1;
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++) begin
					console_cells[i] = BLANK_CELL;
				end
				cursor_col = 0;
				cursor_row = 0;
			end
			ACT_READ: begin
				if (req.cell_index < CELL_COUNT) begin
					res.cell_value = console_cells[req.cell_index];
				end
			end
			default: begin
			end
		endcase
		res.cursor_position = POS_W'(cursor_col + cursor_row * DEF_COLUMNS);
		res.scrolled = did_scroll;
		return res;
	endfunction

	// Compare one result transfer with the oldest awaited result.
	task automatic check_result(input tcw_out_t got);
		tcw_out_t want;

		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("result %p with nothing outstanding", got));
			return;
		end
		want = awaited_results.pop_front();
		if (got.cursor_position != want.cursor_position) begin
			report_mismatch($sformatf("cursor_position %0d, expected %0d",
				got.cursor_position, want.cursor_position));
		end
		if (got.cell_value != want.cell_value) begin
			report_mismatch($sformatf("cell_value %h, expected %h",
				got.cell_value, want.cell_value));
		end
		if (got.scrolled != want.scrolled) begin
			report_mismatch($sformatf("scrolled %b, expected %b", got.scrolled, want.scrolled));
		end
	endtask

	// Results are checked first, then each request transfer is run through the predictor.
	always @(posedge clk) begin
		tcw_out_t predicted;

		if (arst_n) begin
			if (response.valid && response.ready) begin
				check_result(response.payload);
			end
			if (request.valid && request.ready) begin
				predicted = apply_action(request.payload);
				if (pinned_valid) begin
					awaited_results.push_back(pinned_result);
				end else begin
					awaited_results.push_back(predicted);
				end
			end
		end
	end

	// Drive one request and hold it until its transfer.
	task automatic send_request(input tcw_in_t req, input logic pin, input tcw_out_t pin_res);
		int unsigned gap;

		gap = pick_wait(sender_calm);
		@(negedge clk);
		if (gap != 0) begin
			request.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request.valid   <= 1'b1;
		request.payload <= req;
		pinned_valid  = pin;
		pinned_result = pin_res;
		do @(posedge clk); while (!request.ready);
	endtask

	// Weighted random request: mostly text with line feeds often enough to scroll.
	function automatic tcw_in_t make_random_request();
		tcw_in_t     req;
		int unsigned pick;
		int unsigned sub;

		req.action     = ACT_PUT;
		req.char_code  = CHAR_W'($urandom_range(0, 255));
		req.bg_colour  = COLOR_W'($urandom_range(0, 15));
		req.fg_colour  = COLOR_W'($urandom_range(0, 15));
		req.cell_index = IDX_W'($urandom_range(0, INDEX_TOP));
		pick = $urandom_range(0, 99);
		if (pick == 0) begin
			req.action = ACT_CLEAR;
		end else if (pick < 3) begin
			req.action = ACT_SPARE;
		end else if (pick < 18) begin
			req.action = ACT_READ;
			if ($urandom_range(0, 9) == 0) begin
				req.cell_index = IDX_W'($urandom_range(CELL_COUNT, INDEX_TOP));
			end else begin
				req.cell_index = IDX_W'($urandom_range(0, CELL_COUNT - 1));
			end
		end else begin
			sub = $urandom_range(0, 99);
			if (sub < 12) begin
				req.char_code = CODE_LF;
			end else if (sub < 17) begin
				req.char_code = CODE_TAB;
			end else if (sub < 21) begin
				req.char_code = CODE_CR;
			end else if (sub < 27) begin
				req.char_code = CODE_BS;
			end else if (sub < 30) begin
				req.char_code = CHAR_W'($urandom_range(0, 31));
			end else if (sub < 33) begin
				req.char_code = CHAR_W'($urandom_range(128, 255));
			end else begin
				req.char_code = CHAR_W'($urandom_range(32, 127));
			end
		end
		return req;
	endfunction

	// Result side: hold ready low for a drawn wait before each result transfer.
	initial begin
		int unsigned stall;

		response.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_wait(receiver_calm);
			repeat (stall) begin
				@(negedge clk);
				response.ready <= 1'b0;
			end
			@(negedge clk);
			response.ready <= 1'b1;
			do @(posedge clk); while (!(response.valid && response.ready));
		end
	end

	// Main sequence: reset, directed rows, random traffic, drain.
	initial begin
		tcw_in_t req;

		for (int i = 0; i < CELL_COUNT; i++) begin
			console_cells[i] = '0;
		end
		cursor_col      = 0;
		cursor_row      = 0;
		mismatch_count  = 0;
		sender_calm     = 0;
		receiver_calm   = 0;
		pinned_valid    = 1'b0;
		pinned_result   = '0;
		arst_n          = 1'b0;
		request.valid   = 1'b0;
		request.payload = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: the store is cleared before any read of it.
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			send_request(DIRECTED_TABLE[r].item, DIRECTED_TABLE[r].pinned,
				DIRECTED_TABLE[r].result);
		end

		// Random part.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			req = make_random_request();
			send_request(req, 1'b0, '0);
		end
		@(negedge clk);
		request.valid <= 1'b0;

		// Drain outstanding results, then wait out the settle period.
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
